// ----- hw/rtl/fts_pkg.sv -----
// ============================================================================
// fts_pkg
// shared codes, payload types and controller/datapath interface structs
// ============================================================================
package fts_pkg;

   localparam int MAX_THREADS_DEF = 64;

   // command codes
   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_YIELD  = 2'd1;
   localparam logic [1:0] CMD_EXIT   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // target kinds
   localparam logic [1:0] KIND_SELF   = 2'd0;
   localparam logic [1:0] KIND_ANY    = 2'd1;
   localparam logic [1:0] KIND_SPEC   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NONE    = 2'd2;
   localparam logic [1:0] ST_NOMORE  = 2'd3;

   // result id source
   localparam logic [2:0] RES_ZERO = 3'd0;
   localparam logic [2:0] RES_SCAN = 3'd1;
   localparam logic [2:0] RES_HEAD = 3'd2;
   localparam logic [2:0] RES_CUR  = 3'd3;
   localparam logic [2:0] RES_TID  = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] target_kind;
      logic [5:0] target_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] result_id;
      logic [5:0] running_id;
   } rsp_type;

   typedef struct packed {
      logic       latch_req;
      logic       clr_step;
      logic       scan_start;
      logic       scan_step;
      logic       walk_start;
      logic       walk_step;
      logic       do_create;
      logic       do_pop;
      logic       do_remove;
      logic       do_spec;
      logic       fin;
      logic [1:0] fin_status;
      logic [2:0] fin_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic op_create;
      logic op_bad;
      logic op_yield;
      logic kind_self;
      logic kind_any;
      logic q_empty;
      logic tid_ok;
      logic id_used;
      logic scan_hit;
      logic scan_end;
      logic walk_hit;
      logic walk_end;
   } dp_stat_type;

endpackage

// ----- hw/rtl/fts_ram.sv -----
// ============================================================================
// fts_ram
// generic single write port, single read port ram with registered read
// ============================================================================
module fts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fts_datapath.sv -----
// ============================================================================
// fts_datapath
// scheduler state, id map and link memories, free-id scan and queue walk
// ============================================================================
module fts_datapath #(
   parameter int MAX_THREADS = fts_pkg::MAX_THREADS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fts_pkg::req_type     req_data,
   input  fts_pkg::dp_cmd_type  cmd,
   output fts_pkg::dp_stat_type stat,
   output fts_pkg::rsp_type     rsp_data
);

   localparam int IDW = $clog2(MAX_THREADS);
   localparam int CW  = $clog2(MAX_THREADS + 1);
   localparam int WW  = (IDW > 6) ? IDW : 6;
   localparam logic [IDW-1:0] LAST_ID = IDW'(MAX_THREADS - 1);

   fts_pkg::req_type req_ff, req_in;
   logic [IDW-1:0] current_ff, current_in;
   logic [IDW-1:0] head_ff, head_in;
   logic [IDW-1:0] tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IDW-1:0] sa_ff, sa_in;
   logic [IDW-1:0] chk_addr_ff, chk_addr_in;
   logic           chk_valid_ff, chk_valid_in;
   logic [IDW-1:0] cur_p_ff, cur_p_in;
   logic [IDW-1:0] prev_ff, prev_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [5:0]     res_id_ff, res_id_in;

   logic           iu_we, iu_wdata, iu_rdata;
   logic [IDW-1:0] iu_waddr, iu_raddr;
   logic           nx_we;
   logic [IDW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;

   logic [IDW-1:0] tid_idx;
   logic           q_empty, count_one, is_yield, is_self, sa_last;
   logic [1:0]     kind_adj;

   assign tid_idx   = IDW'(req_ff.target_id);
   assign q_empty   = (count_ff == '0);
   assign count_one = (count_ff == CW'(1));
   assign is_yield  = (req_ff.cmd == fts_pkg::CMD_YIELD);
   assign is_self   = (req_ff.target_kind == fts_pkg::KIND_SELF);
   assign sa_last   = (sa_ff == LAST_ID);

   // naming the running id acts as self
   always_comb begin
      kind_adj = req_data.target_kind;
      if ((req_data.cmd == fts_pkg::CMD_YIELD || req_data.cmd == fts_pkg::CMD_EXIT) &&
          req_data.target_kind == fts_pkg::KIND_SPEC &&
          WW'(req_data.target_id) == WW'(current_ff)) begin
         kind_adj = fts_pkg::KIND_SELF;
      end
   end

   always_comb begin
      req_in        = req_ff;
      current_in    = current_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      sa_in         = sa_ff;
      chk_addr_in   = chk_addr_ff;
      chk_valid_in  = chk_valid_ff;
      cur_p_in      = cur_p_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      iu_we         = 1'b0;
      iu_waddr      = sa_ff;
      iu_wdata      = 1'b0;
      iu_raddr      = cmd.scan_step ? sa_ff : tid_idx;
      nx_we         = 1'b0;
      nx_waddr      = tail_ff;
      nx_wdata      = current_ff;
      nx_raddr      = cmd.walk_step ? nx_rdata : head_ff;

      if (cmd.latch_req) begin
         req_in.cmd         = req_data.cmd;
         req_in.target_kind = kind_adj;
         req_in.target_id   = req_data.target_id;
      end

      // post-reset clearing pass of the id map, only id zero in use
      if (cmd.clr_step) begin
         iu_we    = 1'b1;
         iu_waddr = sa_ff;
         iu_wdata = (sa_ff == '0);
         sa_in    = sa_last ? sa_ff : sa_ff + IDW'(1);
      end

      if (cmd.scan_start) begin
         sa_in        = '0;
         chk_valid_in = 1'b0;
      end

      if (cmd.scan_step) begin
         sa_in        = sa_last ? sa_ff : sa_ff + IDW'(1);
         chk_addr_in  = sa_ff;
         chk_valid_in = 1'b1;
      end

      if (cmd.do_create) begin
         iu_we    = 1'b1;
         iu_waddr = chk_addr_ff;
         iu_wdata = 1'b1;
         if (q_empty) begin
            head_in = chk_addr_ff;
         end else begin
            nx_we    = 1'b1;
            nx_waddr = tail_ff;
            nx_wdata = chk_addr_ff;
         end
         tail_in  = chk_addr_ff;
         count_in = count_ff + CW'(1);
      end

      // nx_rdata holds the link of the head here
      if (cmd.do_pop) begin
         if (is_yield) begin
            head_in = count_one ? current_ff : nx_rdata;
            if (!count_one) begin
               nx_we    = 1'b1;
               nx_waddr = tail_ff;
               nx_wdata = current_ff;
            end
            tail_in    = current_ff;
            current_in = head_ff;
         end else if (is_self) begin
            head_in    = count_one ? head_ff : nx_rdata;
            count_in   = count_ff - CW'(1);
            iu_we      = 1'b1;
            iu_waddr   = current_ff;
            current_in = head_ff;
         end else begin
            head_in  = count_one ? head_ff : nx_rdata;
            count_in = count_ff - CW'(1);
            iu_we    = 1'b1;
            iu_waddr = head_ff;
         end
      end

      if (cmd.walk_start) begin
         cur_p_in = head_ff;
         prev_in  = head_ff;
         idx_in   = '0;
      end

      if (cmd.walk_step) begin
         prev_in  = cur_p_ff;
         cur_p_in = nx_rdata;
         idx_in   = idx_ff + CW'(1);
      end

      // unlink cur_p; nx_rdata holds its successor
      if (cmd.do_remove) begin
         count_in = count_ff - CW'(1);
         if (idx_ff == '0) begin
            if (!count_one) begin
               head_in = nx_rdata;
            end
         end else if (idx_ff + CW'(1) == count_ff) begin
            tail_in = prev_ff;
         end else begin
            nx_we    = 1'b1;
            nx_waddr = prev_ff;
            nx_wdata = nx_rdata;
         end
      end

      if (cmd.do_spec) begin
         if (is_yield) begin
            if (q_empty) begin
               head_in = current_ff;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = tail_ff;
               nx_wdata = current_ff;
            end
            tail_in    = current_ff;
            count_in   = count_ff + CW'(1);
            current_in = tid_idx;
         end else begin
            iu_we    = 1'b1;
            iu_waddr = tid_idx;
         end
      end

      if (cmd.fin) begin
         res_status_in = cmd.fin_status;
         case (cmd.fin_sel)
            fts_pkg::RES_SCAN: res_id_in = 6'(chk_addr_ff);
            fts_pkg::RES_HEAD: res_id_in = 6'(head_ff);
            fts_pkg::RES_CUR:  res_id_in = 6'(current_ff);
            fts_pkg::RES_TID:  res_id_in = req_ff.target_id;
            default:           res_id_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sa_ff        <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         current_ff   <= current_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sa_ff        <= sa_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      chk_addr_ff   <= chk_addr_in;
      cur_p_ff      <= cur_p_in;
      prev_ff       <= prev_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
   end

   fts_ram #(.WIDTH(1), .DEPTH(MAX_THREADS)) u_in_use (
      .clock   (clock),
      .wr_en   (iu_we),
      .wr_addr (iu_waddr),
      .wr_data (iu_wdata),
      .rd_addr (iu_raddr),
      .rd_data (iu_rdata)
   );

   fts_ram #(.WIDTH(IDW), .DEPTH(MAX_THREADS)) u_next (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (nx_raddr),
      .rd_data (nx_rdata)
   );

   always_comb begin
      stat.clr_last  = sa_last;
      stat.op_create = (req_ff.cmd == fts_pkg::CMD_CREATE);
      stat.op_bad    = (req_ff.cmd == fts_pkg::CMD_UNUSED) ||
                       (req_ff.target_kind == fts_pkg::KIND_UNUSED);
      stat.op_yield  = is_yield;
      stat.kind_self = is_self;
      stat.kind_any  = (req_ff.target_kind == fts_pkg::KIND_ANY);
      stat.q_empty   = q_empty;
      stat.tid_ok    = (32'(req_ff.target_id) < MAX_THREADS);
      stat.id_used   = iu_rdata;
      stat.scan_hit  = chk_valid_ff && !iu_rdata;
      stat.scan_end  = chk_valid_ff && iu_rdata && (chk_addr_ff == LAST_ID);
      stat.walk_hit  = (cur_p_ff == tid_idx);
      stat.walk_end  = ((idx_ff + CW'(1)) == count_ff);
   end

   assign rsp_data.status     = res_status_ff;
   assign rsp_data.result_id  = res_id_ff;
   assign rsp_data.running_id = 6'(current_ff);

endmodule

// ----- hw/rtl/fts_ctrl.sv -----
// ============================================================================
// fts_ctrl
// command sequencer: clearing pass, dispatch, scan, pop, walk and response
// ============================================================================
module fts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fts_pkg::dp_stat_type stat,
   output fts_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_POP    = 4'd4;
   localparam logic [3:0] S_CHKUSE = 4'd5;
   localparam logic [3:0] S_WALK   = 4'd6;
   localparam logic [3:0] S_SPEC   = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_RESP;
            if (stat.op_create) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else if (stat.op_bad) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = fts_pkg::ST_INVALID;
               cmd.fin_sel    = fts_pkg::RES_ZERO;
            end else if (stat.kind_self && stat.op_yield) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = fts_pkg::ST_OK;
               cmd.fin_sel    = fts_pkg::RES_CUR;
            end else if (stat.kind_self || stat.kind_any) begin
               if (stat.q_empty) begin
                  cmd.fin        = 1'b1;
                  cmd.fin_status = fts_pkg::ST_NONE;
                  cmd.fin_sel    = fts_pkg::RES_ZERO;
               end else begin
                  state_in = S_POP;
               end
            end else if (!stat.tid_ok) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = fts_pkg::ST_INVALID;
               cmd.fin_sel    = fts_pkg::RES_ZERO;
            end else begin
               state_in = S_CHKUSE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               cmd.do_create  = 1'b1;
               cmd.fin        = 1'b1;
               cmd.fin_status = fts_pkg::ST_OK;
               cmd.fin_sel    = fts_pkg::RES_SCAN;
               state_in       = S_RESP;
            end else if (stat.scan_end) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = fts_pkg::ST_NOMORE;
               cmd.fin_sel    = fts_pkg::RES_ZERO;
               state_in       = S_RESP;
            end
         end
         S_POP: begin
            cmd.do_pop     = 1'b1;
            cmd.fin        = 1'b1;
            cmd.fin_status = fts_pkg::ST_OK;
            cmd.fin_sel    = fts_pkg::RES_HEAD;
            state_in       = S_RESP;
         end
         S_CHKUSE: begin
            if (!stat.id_used || stat.q_empty) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = fts_pkg::ST_INVALID;
               cmd.fin_sel    = fts_pkg::RES_ZERO;
               state_in       = S_RESP;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = S_WALK;
            end
         end
         S_WALK: begin
            if (stat.walk_hit) begin
               cmd.do_remove = 1'b1;
               state_in      = S_SPEC;
            end else if (stat.walk_end) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = fts_pkg::ST_INVALID;
               cmd.fin_sel    = fts_pkg::RES_ZERO;
               state_in       = S_RESP;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_SPEC: begin
            cmd.do_spec    = 1'b1;
            cmd.fin        = 1'b1;
            cmd.fin_status = fts_pkg::ST_OK;
            cmd.fin_sel    = fts_pkg::RES_TID;
            state_in       = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

// ----- hw/rtl/fifo_thread_scheduler.sv -----
// ============================================================================
// fifo_thread_scheduler
// round-robin thread id scheduler: running id, fifo ready queue, id map
// ============================================================================
//
//  channel   ports                          handshake
//  --------  -----------------------------  ------------------------------------
//  request   start, busy, req_data          item taken when start & !busy
//  result    rsp_strobe, rsp_data           one cycle strobe, always taken
//
//  one item at a time; busy rises at the accept edge and stays high through
//  the result strobe cycle, low again in the cycle after it
//  create: the lowest free id is found by an id map memory scan, one entry read
//  per cycle, up to the whole map when it is full
//  named id: found by a link memory walk from the queue head, one hop per
//  cycle; self and any targets are served from the queue head without a walk
//  after reset the id map is cleared one entry a cycle, with busy high
//  the result side has no backpressure
//
module fifo_thread_scheduler #(
   parameter int MAX_THREADS = fts_pkg::MAX_THREADS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  fts_pkg::req_type req_data,
   // result channel
   output logic             rsp_strobe,
   output fts_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   fts_pkg::dp_cmd_type  dp_cmd;
   fts_pkg::dp_stat_type dp_stat;

   // sequencer: decides each cycle's datapath operation
   fts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (dp_stat),
      .cmd        (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // datapath: queue pointers, running id, id map and link memories
   fts_datapath #(.MAX_THREADS(MAX_THREADS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (dp_cmd),
      .stat     (dp_stat),
      .rsp_data (rsp_data)
   );

endmodule

// ----- hw/rtl/fts_checker.sv -----
// ============================================================================
// fts_checker
// port-level checks of the scheduler handshake and result contents
// ============================================================================
module fts_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input fts_pkg::rsp_type rsp_data
);

   // accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after accept");

   // result only while busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // single strobe, then idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("no return to idle after result");

   // failed commands report id zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != fts_pkg::ST_OK) |-> (rsp_data.result_id == 6'd0))
      else $error("nonzero id on failed command");

endmodule

bind fifo_thread_scheduler fts_checker u_fts_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- tb/tb.sv -----
// ============================================================================
// tb
// self-checking bench for fifo_thread_scheduler: directed command cases, then
// random create/yield/exit traffic with undefined codes, every reply checked
// against a scheduler model kept inside the bench
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fts_pkg::*;

   localparam int NTHREADS    = MAX_THREADS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_GAP     = 30;
   localparam int BLOCK_ITEMS = 150;
   localparam int NUM_BLOCKS  = 12;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // sender idle percentage per phase, all-zero phases give back-to-back items
   int idle_pct;
   int idle_plan [4] = '{0, 67, 0, 17};

   int          error_count = 0;
   int unsigned cycle_count = 0;

   // replies predicted at accept time, oldest first
   rsp_type replies_due [$];

   // scheduler model state
   bit id_taken   [NTHREADS];
   int ready_link [NTHREADS];
   int ready_head;
   int ready_tail;
   int ready_len;
   int running;

   fifo_thread_scheduler #(
      .MAX_THREADS(NTHREADS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // scheduler model
   // ---------------------------------------------------------------------

   function automatic void sched_model_reset();
      for (int i = 0; i < NTHREADS; i++) begin
         id_taken[i]   = 1'b0;
         ready_link[i] = 0;
      end
      id_taken[0] = 1'b1;
      ready_head  = 0;
      ready_tail  = 0;
      ready_len   = 0;
      running     = 0;
   endfunction

   function automatic void ready_push(int id);
      if (ready_len == 0) begin
         ready_head = id;
      end else begin
         ready_link[ready_tail] = id;
      end
      ready_tail = id;
      ready_len++;
   endfunction

   function automatic int ready_pop();
      int h;
      h = ready_head;
      ready_len--;
      if (ready_len != 0) begin
         ready_head = ready_link[h];
      end
      return h;
   endfunction

   // unlink a named id anywhere in the ready list, 0 if it is not queued
   function automatic bit ready_unlink(int id);
      int p;
      int prev;
      p    = ready_head;
      prev = 0;
      for (int i = 0; i < ready_len; i++) begin
         if (p == id) begin
            if (i == 0) begin
               void'(ready_pop());
            end else begin
               if (i + 1 == ready_len) begin
                  ready_tail = prev;
               end else begin
                  ready_link[prev] = ready_link[p];
               end
               ready_len--;
            end
            return 1'b1;
         end
         prev = p;
         if (i + 1 < ready_len) begin
            p = ready_link[p];
         end
      end
      return 1'b0;
   endfunction

   // apply one command to the model and return the reply it should give
   function automatic rsp_type schedule_step(req_type r);
      rsp_type    reply;
      logic [1:0] kind;
      logic [1:0] st;
      int         tid;
      int         res;
      int         h;
      int         free_id;
      kind    = r.target_kind;
      tid     = int'(r.target_id);
      st      = ST_OK;
      res     = 0;
      free_id = -1;

      // naming the running id is the same as naming self
      if ((r.cmd == CMD_YIELD || r.cmd == CMD_EXIT) && kind == KIND_SPEC && tid == running) begin
         kind = KIND_SELF;
      end

      if (r.cmd == CMD_CREATE) begin
         for (int i = 0; i < NTHREADS; i++) begin
            if (!id_taken[i]) begin
               free_id = i;
               break;
            end
         end
         if (free_id < 0) begin
            st = ST_NOMORE;
         end else begin
            id_taken[free_id] = 1'b1;
            ready_push(free_id);
            res = free_id;
         end
      end else if (r.cmd == CMD_UNUSED || kind == KIND_UNUSED) begin
         st = ST_INVALID;
      end else if (kind == KIND_SELF) begin
         if (r.cmd == CMD_YIELD) begin
            res = running;
         end else if (ready_len == 0) begin
            st = ST_NONE;
         end else begin
            h = ready_pop();
            id_taken[running] = 1'b0;
            running = h;
            res = h;
         end
      end else if (kind == KIND_ANY) begin
         if (ready_len == 0) begin
            st = ST_NONE;
         end else begin
            h = ready_pop();
            if (r.cmd == CMD_YIELD) begin
               ready_push(running);
               running = h;
            end else begin
               id_taken[h] = 1'b0;
            end
            res = h;
         end
      end else begin
         if (tid >= NTHREADS || !id_taken[tid] || !ready_unlink(tid)) begin
            st = ST_INVALID;
         end else begin
            if (r.cmd == CMD_YIELD) begin
               ready_push(running);
               running = tid;
            end else begin
               id_taken[tid] = 1'b0;
            end
            res = tid;
         end
      end

      reply.status     = st;
      reply.result_id  = 6'(res);
      reply.running_id = 6'(running);
      return reply;
   endfunction

   // ---------------------------------------------------------------------
   // reply checker, samples at the rising edge that ends the strobe cycle
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : check_replies
      rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected reply, expected none, got status %0d result %0d running %0d",
                     $time, rsp_data.status, rsp_data.result_id, rsp_data.running_id);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_data.status !== want.status || rsp_data.result_id !== want.result_id ||
                rsp_data.running_id !== want.running_id) begin
               $display("%0t: mismatch, expected status %0d result %0d running %0d, got status %0d result %0d running %0d",
                        $time, want.status, want.result_id, want.running_id,
                        rsp_data.status, rsp_data.result_id, rsp_data.running_id);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // send one item: optional idle gap, then hold start until busy is low
   task automatic issue_cmd(input logic [1:0] cmd, input logic [1:0] kind,
                            input logic [5:0] tid);
      req_type item;
      int      gap;
      item.cmd         = cmd;
      item.target_kind = kind;
      item.target_id   = tid;
      gap = 0;
      while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      // accept edge is the first rising edge that sees busy low
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      replies_due.push_back(schedule_step(item));
   endtask

   // mostly a queued id so named targets get past the lookup
   function automatic int pick_target();
      int r;
      int p;
      int pos;
      r = $urandom_range(99);
      if (r < 65 && ready_len > 0) begin
         p   = ready_head;
         pos = $urandom_range(ready_len - 1);
         for (int i = 0; i < pos; i++) begin
            p = ready_link[p];
         end
         return p;
      end else if (r < 75) begin
         return running;
      end
      return $urandom_range(63);
   endfunction

   task automatic random_cmd(input bit grow);
      int         r;
      logic [1:0] cmd;
      logic [1:0] kind;
      int         tid;
      r = $urandom_range(99);
      if (grow) begin
         cmd = (r < 60) ? CMD_CREATE : (r < 82) ? CMD_YIELD : (r < 97) ? CMD_EXIT : CMD_UNUSED;
      end else begin
         cmd = (r < 20) ? CMD_CREATE : (r < 50) ? CMD_YIELD : (r < 96) ? CMD_EXIT : CMD_UNUSED;
      end
      r = $urandom_range(99);
      kind = (r < 25) ? KIND_SELF : (r < 55) ? KIND_ANY : (r < 96) ? KIND_SPEC : KIND_UNUSED;
      tid  = (kind == KIND_SPEC) ? pick_target() : $urandom_range(63);
      issue_cmd(cmd, kind, 6'(tid));
   endtask

   // fresh scheduler, nothing ready: every target form on an empty queue
   task automatic test_empty_queue();
      idle_pct = 0;
      issue_cmd(CMD_YIELD, KIND_SELF, 6'd0);
      issue_cmd(CMD_YIELD, KIND_ANY,  6'd0);
      issue_cmd(CMD_EXIT,  KIND_SELF, 6'd0);
      issue_cmd(CMD_EXIT,  KIND_ANY,  6'd63);
      issue_cmd(CMD_YIELD, KIND_SPEC, 6'd5);
      issue_cmd(CMD_EXIT,  KIND_SPEC, 6'd63);
      // own id named explicitly
      issue_cmd(CMD_YIELD, KIND_SPEC, 6'd0);
      issue_cmd(CMD_EXIT,  KIND_SPEC, 6'd0);
   endtask

   // undefined command and target codes
   task automatic test_unused_codes();
      idle_pct = 67;
      issue_cmd(CMD_UNUSED, KIND_SELF,   6'd0);
      issue_cmd(CMD_UNUSED, KIND_SPEC,   6'd63);
      issue_cmd(CMD_YIELD,  KIND_UNUSED, 6'd21);
      issue_cmd(CMD_EXIT,   KIND_UNUSED, 6'd42);
   endtask

   // create a few threads and switch among them
   task automatic test_create_and_switch();
      idle_pct = 17;
      // create ignores its target fields
      issue_cmd(CMD_CREATE, KIND_UNUSED, 6'd63);
      issue_cmd(CMD_CREATE, KIND_SPEC,   6'd0);
      issue_cmd(CMD_CREATE, KIND_SELF,   6'd0);
      issue_cmd(CMD_YIELD,  KIND_SPEC,   6'd2);
      issue_cmd(CMD_YIELD,  KIND_ANY,    6'd0);
      issue_cmd(CMD_YIELD,  KIND_SPEC,   6'(running));
   endtask

   // each exit form, then reuse of the lowest freed id
   task automatic test_exit_forms();
      idle_pct = 0;
      issue_cmd(CMD_EXIT,   KIND_SPEC, 6'(ready_tail));
      issue_cmd(CMD_EXIT,   KIND_SPEC, 6'd40);
      issue_cmd(CMD_EXIT,   KIND_ANY,  6'd0);
      issue_cmd(CMD_EXIT,   KIND_SELF, 6'd0);
      issue_cmd(CMD_CREATE, KIND_SELF, 6'd0);
   endtask

   // alternating grow and drain blocks: the map fills up, the queue gets
   // long for deep named lookups, and drains back to empty
   task automatic test_random_traffic();
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         idle_pct = idle_plan[(b / 2) % 4];
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            random_cmd(b % 2 == 0);
         end
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      idle_pct = 0;
      sched_model_reset();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_unused_codes();
      test_create_and_switch();
      test_exit_forms();
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      // room for a stray late reply
      repeat (NTHREADS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
